// File: rtl/tusp_pkg.sv
package tusp_pkg;

  // Header geometry
  localparam int unsigned BLOCK_BYTES    = 512;
  localparam int unsigned POS_W          = 9;
  localparam int unsigned SUFFIX_END     = 100;
  localparam int unsigned SIZE_FIRST     = 124;
  localparam int unsigned SIZE_BOUND     = 136;
  localparam int unsigned TYPE_POS       = 156;
  localparam int unsigned MAGIC_FIRST    = 257;
  localparam int unsigned MAGIC_LEN      = 5;
  localparam int unsigned PREFIX_FIRST   = 345;
  localparam int unsigned PREFIX_END     = 500;
  localparam int unsigned LAST_POS       = BLOCK_BYTES - 1;
  localparam logic [8:0]  PAD_MASK       = 9'h1FF;

  // Size field
  localparam int unsigned ACC_W          = 36;
  localparam int unsigned SIZE_W         = 31;
  localparam logic [ACC_W-1:0] MAX_ENTRY_SIZE = 36'd2147483647;

  // Type bytes
  localparam logic [7:0] TYPE_REG_CHAR   = 8'h30;  // '0'
  localparam logic [7:0] TYPE_REG_NUL    = 8'h00;
  localparam logic [7:0] TYPE_LONG_NAME  = 8'h4C;  // 'L'

  // Result kinds
  localparam logic [2:0] KIND_SUFFIX     = 3'd0;
  localparam logic [2:0] KIND_PREFIX     = 3'd1;
  localparam logic [2:0] KIND_LONG_NAME  = 3'd2;
  localparam logic [2:0] KIND_CONTENT    = 3'd3;
  localparam logic [2:0] KIND_ENTRY      = 3'd4;
  localparam logic [2:0] KIND_OK         = 3'd5;
  localparam logic [2:0] KIND_NOT_USTAR  = 3'd6;
  localparam logic [2:0] KIND_ERROR      = 3'd7;

  // Name sources
  localparam logic [1:0] SRC_SUFFIX      = 2'd0;
  localparam logic [1:0] SRC_PREFIX      = 2'd1;
  localparam logic [1:0] SRC_LONG        = 2'd2;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        out_byte;
    logic [7:0]        name_index;
    logic [SIZE_W-1:0] entry_size;
    logic [1:0]        name_source;
    logic [7:0]        entry_type;
    logic              last_of_run;
  } result_t;

  // Expected "ustar" magic character at a given offset
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = 8'h75;  // u
      3'd1:    c = 8'h73;  // s
      3'd2:    c = 8'h74;  // t
      3'd3:    c = 8'h61;  // a
      3'd4:    c = 8'h72;  // r
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/tar_ustar_stream_parser.sv
// Channel  Handshake                   Payload
// byte     byte_valid / byte_stall     data_byte, stream_end
// result   result_valid / result_stall kind, out_byte, name_index, entry_size,
//                                      name_source, entry_type, last_of_run
//
// One archive byte per cycle while byte_stall is low. Each byte is registered in the
// input register; the parse logic then writes its result into a two-entry result
// buffer once the buffer has room, and the result transfers from there.
// Throughput is set by the header/content state update.
// rst is synchronous: parser returns to the first header byte, buffers empty.
// byte_stall rises only when the input register is full and the result buffer
// holds two untaken results.
module tar_ustar_stream_parser (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        byte_valid,
  output logic                        byte_stall,
  input  logic [7:0]                  data_byte,
  input  logic                        stream_end,
  output logic                        result_valid,
  input  logic                        result_stall,
  output logic [2:0]                  kind,
  output logic [7:0]                  out_byte,
  output logic [7:0]                  name_index,
  output logic [tusp_pkg::SIZE_W-1:0] entry_size,
  output logic [1:0]                  name_source,
  output logic [7:0]                  entry_type,
  output logic                        last_of_run
);

  logic              in_full;
  logic [7:0]        in_byte;
  logic              in_end;
  logic              go, room, step_valid, buf_valid;
  tusp_pkg::result_t step_res, head;

  assign go         = in_full && room;
  assign byte_stall = in_full && !room;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (!byte_stall) begin
      in_full <= byte_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!byte_stall && byte_valid) begin
      in_byte <= data_byte;
      in_end  <= stream_end;
    end
  end

  tusp_step u_step (
    .clk       (clk),
    .rst       (rst),
    .go        (go),
    .data_byte (in_byte),
    .stream_end(in_end),
    .res_valid (step_valid),
    .res       (step_res)
  );

  tusp_out_buf u_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (go && step_valid),
    .push_data(step_res),
    .room     (room),
    .pop      (buf_valid && !result_stall),
    .not_empty(buf_valid),
    .head     (head)
  );

  assign result_valid = buf_valid;
  assign kind         = head.kind;
  assign out_byte     = head.out_byte;
  assign name_index   = head.name_index;
  assign entry_size   = head.entry_size;
  assign name_source  = head.name_source;
  assign entry_type   = head.entry_type;
  assign last_of_run  = head.last_of_run;

endmodule

// File: rtl/tusp_step.sv
module tusp_step (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [7:0]        data_byte,
  input  logic              stream_end,
  output logic              res_valid,
  output tusp_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_FILE, PH_LONG, PH_SKIP, PH_PAD, PH_DONE
  } phase_t;

  typedef enum logic [1:0] {
    SZ_SPACE, SZ_SIGN, SZ_DIGITS, SZ_STOP
  } size_phase_t;

  phase_t                          phase, phase_next;
  logic [tusp_pkg::POS_W-1:0]      byte_position, byte_position_next;
  logic                            all_zero, all_zero_next;
  logic                            zero_seen, zero_seen_next;
  logic                            suffix_done, suffix_done_next;
  logic                            prefix_done, prefix_done_next;
  logic                            prefix_nonempty, prefix_nonempty_next;
  size_phase_t                     size_phase, size_phase_next;
  logic [tusp_pkg::ACC_W-1:0]      size_acc, size_acc_next;
  logic                            size_neg, size_neg_next;
  logic                            magic_ok, magic_ok_next;
  logic [7:0]                      type_byte, type_byte_next;
  logic                            long_pending, long_pending_next;
  logic [tusp_pkg::SIZE_W-1:0]     bytes_rem, bytes_rem_next;
  logic [8:0]                      pad_rem, pad_rem_next;

  logic                            is_space, is_digit, bad_size, run_last;
  logic [tusp_pkg::SIZE_W-1:0]     size_val;
  logic [2:0]                      magic_idx;
  logic [tusp_pkg::POS_W-1:0]      pos_rel;

  assign is_space = (data_byte == 8'h20) || (data_byte >= 8'h09 && data_byte <= 8'h0D);
  assign is_digit = (data_byte >= 8'h30) && (data_byte <= 8'h37);
  assign size_val = size_acc[tusp_pkg::SIZE_W-1:0];
  assign pos_rel  = byte_position - tusp_pkg::POS_W'(tusp_pkg::MAGIC_FIRST);
  assign magic_idx = pos_rel[2:0];

  // One archive byte: header field parsing, content and pad counting
  always_comb begin
    phase_next           = phase;
    byte_position_next   = byte_position;
    all_zero_next        = all_zero;
    zero_seen_next       = zero_seen;
    suffix_done_next     = suffix_done;
    prefix_done_next     = prefix_done;
    prefix_nonempty_next = prefix_nonempty;
    size_phase_next      = size_phase;
    size_acc_next        = size_acc;
    size_neg_next        = size_neg;
    magic_ok_next        = magic_ok;
    type_byte_next       = type_byte;
    long_pending_next    = long_pending;
    bytes_rem_next       = bytes_rem;
    pad_rem_next         = pad_rem;
    res_valid            = 1'b0;
    res                  = '0;
    bad_size             = 1'b0;
    run_last             = 1'b0;

    if (phase == PH_DONE) begin
      res_valid = 1'b0;
    end else if (stream_end) begin
      // truncated archive
      phase_next = PH_DONE;
      res_valid  = 1'b1;
      res.kind   = tusp_pkg::KIND_ERROR;
    end else begin
      unique case (phase)
        PH_HEADER: begin
          if (data_byte != 8'h00) all_zero_next = 1'b0;

          // name suffix
          if (byte_position < tusp_pkg::POS_W'(tusp_pkg::SUFFIX_END) && !suffix_done) begin
            if (data_byte == 8'h00) begin
              suffix_done_next = 1'b1;
            end else if (!zero_seen) begin
              res_valid      = 1'b1;
              res.kind       = tusp_pkg::KIND_SUFFIX;
              res.out_byte   = data_byte;
              res.name_index = byte_position[7:0];
            end
          end

          // name prefix
          if (byte_position >= tusp_pkg::POS_W'(tusp_pkg::PREFIX_FIRST) &&
              byte_position < tusp_pkg::POS_W'(tusp_pkg::PREFIX_END) && !prefix_done) begin
            if (byte_position == tusp_pkg::POS_W'(tusp_pkg::PREFIX_FIRST) &&
                data_byte != 8'h00) begin
              prefix_nonempty_next = 1'b1;
            end
            if (data_byte == 8'h00) begin
              prefix_done_next = 1'b1;
            end else if (!zero_seen) begin
              res_valid      = 1'b1;
              res.kind       = tusp_pkg::KIND_PREFIX;
              res.out_byte   = data_byte;
              res.name_index = 8'(byte_position - tusp_pkg::POS_W'(tusp_pkg::PREFIX_FIRST));
            end
          end

          // size field, strtol style
          if (byte_position >= tusp_pkg::POS_W'(tusp_pkg::SIZE_FIRST) &&
              byte_position < tusp_pkg::POS_W'(tusp_pkg::SIZE_BOUND)) begin
            if (size_phase == SZ_SPACE && is_space) begin
              size_phase_next = SZ_SPACE;
            end else if (size_phase == SZ_SPACE &&
                         (data_byte == 8'h2B || data_byte == 8'h2D)) begin
              size_neg_next   = (data_byte == 8'h2D);
              size_phase_next = SZ_SIGN;
            end else if (size_phase == SZ_SPACE || size_phase == SZ_SIGN) begin
              if (is_digit) begin
                size_acc_next   = tusp_pkg::ACC_W'(data_byte[2:0]);
                size_phase_next = SZ_DIGITS;
              end else begin
                size_acc_next   = '1;
                size_neg_next   = 1'b0;
                size_phase_next = SZ_STOP;
              end
            end else if (size_phase == SZ_DIGITS) begin
              if (is_digit) size_acc_next = {size_acc[tusp_pkg::ACC_W-4:0], data_byte[2:0]};
              else size_phase_next = SZ_STOP;
            end
          end

          if (byte_position == tusp_pkg::POS_W'(tusp_pkg::TYPE_POS)) type_byte_next = data_byte;

          if (byte_position >= tusp_pkg::POS_W'(tusp_pkg::MAGIC_FIRST) &&
              byte_position < tusp_pkg::POS_W'(tusp_pkg::MAGIC_FIRST + tusp_pkg::MAGIC_LEN) &&
              data_byte != tusp_pkg::magic_char(magic_idx)) begin
            magic_ok_next = 1'b0;
          end

          byte_position_next = byte_position + 1'b1;

          // end of header: verdict or entry start
          if (byte_position == tusp_pkg::POS_W'(tusp_pkg::LAST_POS)) begin
            byte_position_next = byte_position;
            bad_size = (size_phase == SZ_SPACE) || (size_phase == SZ_SIGN) ||
                       (size_neg && size_acc != '0) || (size_acc > tusp_pkg::MAX_ENTRY_SIZE);
            res_valid = 1'b1;
            res       = '0;
            if (zero_seen) begin
              phase_next = PH_DONE;
              res.kind   = all_zero_next ? tusp_pkg::KIND_OK : tusp_pkg::KIND_ERROR;
            end else if (all_zero_next) begin
              res_valid      = 1'b0;
              zero_seen_next = 1'b1;
              phase_next     = PH_HEADER;
            end else if (bad_size) begin
              phase_next = PH_DONE;
              res.kind   = tusp_pkg::KIND_ERROR;
            end else if (!magic_ok) begin
              phase_next = PH_DONE;
              res.kind   = tusp_pkg::KIND_NOT_USTAR;
            end else begin
              res.kind        = tusp_pkg::KIND_ENTRY;
              res.entry_size  = size_val;
              res.name_source = long_pending ? tusp_pkg::SRC_LONG :
                                (prefix_nonempty ? tusp_pkg::SRC_PREFIX : tusp_pkg::SRC_SUFFIX);
              res.entry_type  = type_byte;
              long_pending_next = 1'b0;
              bytes_rem_next    = size_val;
              pad_rem_next      = (9'd0 - size_val[8:0]) & tusp_pkg::PAD_MASK;
              if (size_val != '0) begin
                if (type_byte == tusp_pkg::TYPE_REG_CHAR || type_byte == tusp_pkg::TYPE_REG_NUL)
                  phase_next = PH_FILE;
                else if (type_byte == tusp_pkg::TYPE_LONG_NAME)
                  phase_next = PH_LONG;
                else
                  phase_next = PH_SKIP;
              end else begin
                // empty entry: no content and no padding
                if (type_byte == tusp_pkg::TYPE_LONG_NAME) long_pending_next = 1'b1;
                phase_next = PH_HEADER;
              end
            end
          end
        end

        PH_FILE, PH_LONG, PH_SKIP: begin
          bytes_rem_next = bytes_rem - 1'b1;
          run_last       = (bytes_rem_next == '0);
          if (run_last) begin
            if (phase == PH_LONG) long_pending_next = 1'b1;
            phase_next = (pad_rem != '0) ? PH_PAD : PH_HEADER;
          end
          if (phase != PH_SKIP) begin
            res_valid       = 1'b1;
            res.kind        = (phase == PH_FILE) ? tusp_pkg::KIND_CONTENT : tusp_pkg::KIND_LONG_NAME;
            res.out_byte    = data_byte;
            res.last_of_run = run_last;
          end
        end

        PH_PAD: begin
          pad_rem_next = pad_rem - 1'b1;
          if (pad_rem_next == '0) phase_next = PH_HEADER;
        end

        default: begin
          phase_next = PH_DONE;
        end
      endcase

      // fresh header: clear per-header state
      if (phase_next == PH_HEADER &&
          (phase != PH_HEADER || byte_position == tusp_pkg::POS_W'(tusp_pkg::LAST_POS))) begin
        byte_position_next   = '0;
        all_zero_next        = 1'b1;
        suffix_done_next     = 1'b0;
        prefix_done_next     = 1'b0;
        prefix_nonempty_next = 1'b0;
        size_phase_next      = SZ_SPACE;
        size_acc_next        = '0;
        size_neg_next        = 1'b0;
        magic_ok_next        = 1'b1;
        type_byte_next       = '0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_HEADER;
      byte_position   <= '0;
      all_zero        <= 1'b1;
      zero_seen       <= 1'b0;
      suffix_done     <= 1'b0;
      prefix_done     <= 1'b0;
      prefix_nonempty <= 1'b0;
      size_phase      <= SZ_SPACE;
      size_acc        <= '0;
      size_neg        <= 1'b0;
      magic_ok        <= 1'b1;
      type_byte       <= '0;
      long_pending    <= 1'b0;
      bytes_rem       <= '0;
      pad_rem         <= '0;
    end else if (go) begin
      phase           <= phase_next;
      byte_position   <= byte_position_next;
      all_zero        <= all_zero_next;
      zero_seen       <= zero_seen_next;
      suffix_done     <= suffix_done_next;
      prefix_done     <= prefix_done_next;
      prefix_nonempty <= prefix_nonempty_next;
      size_phase      <= size_phase_next;
      size_acc        <= size_acc_next;
      size_neg        <= size_neg_next;
      magic_ok        <= magic_ok_next;
      type_byte       <= type_byte_next;
      long_pending    <= long_pending_next;
      bytes_rem       <= bytes_rem_next;
      pad_rem         <= pad_rem_next;
    end
  end

  a_done_quiet: assert property (@(posedge clk) disable iff (rst)
    phase == PH_DONE |-> !res_valid)
    else $error("result produced after final verdict");

  a_verdict_final: assert property (@(posedge clk) disable iff (rst)
    go && res_valid && (res.kind == tusp_pkg::KIND_ERROR || res.kind == tusp_pkg::KIND_OK ||
    res.kind == tusp_pkg::KIND_NOT_USTAR) |=> phase == PH_DONE)
    else $error("verdict did not end the archive");

  a_entry_at_end: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.kind == tusp_pkg::KIND_ENTRY |->
    byte_position == tusp_pkg::POS_W'(tusp_pkg::LAST_POS))
    else $error("entry start away from last header byte");

endmodule

// File: rtl/tusp_out_buf.sv
module tusp_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  tusp_pkg::result_t push_data,
  output logic              room,
  input  logic              pop,
  output logic              not_empty,
  output tusp_pkg::result_t head
);

  tusp_pkg::result_t mem [2];
  logic              wr_ptr, rd_ptr;
  logic [1:0]        count;

  assign room      = (count != 2'd2);
  assign not_empty = (count != 2'd0);
  assign head      = mem[rd_ptr];

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> room)
    else $error("result buffer overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("result buffer underflow");

endmodule

// File: sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import tusp_pkg::*;

  // Parser walk through the archive
  typedef enum logic [2:0] {
    ST_HEADER, ST_FILE, ST_LONG, ST_SKIP, ST_PAD, ST_DONE
  } walk_t;

  // Scan of the octal size field
  typedef enum logic [1:0] {
    SZ_BLANK, SZ_SIGNED, SZ_DIGITS, SZ_STOPPED
  } size_scan_t;

  typedef struct {
    logic [7:0] b;
    logic       eos;
    bit         hold;   // wait for every pending result before this transfer
  } arc_item_t;

  localparam logic [39:0] USTAR_TEXT = "ustar";
  localparam logic [7:0]  CH_ZERO    = "0";
  localparam logic [7:0]  CH_SEVEN   = "7";
  localparam logic [7:0]  CH_PLUS    = "+";
  localparam logic [7:0]  CH_MINUS   = "-";
  localparam logic [7:0]  CH_SPACE   = " ";
  localparam int unsigned SIZE_LEN   = SIZE_BOUND - SIZE_FIRST;
  localparam int unsigned PREFIX_SPAN = PREFIX_END - PREFIX_FIRST;
  localparam int unsigned ARCHIVE_BYTES = 1550;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              byte_valid = 1'b0;
  logic              byte_stall;
  logic [7:0]        data_byte = 8'h00;
  logic              stream_end = 1'b0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [2:0]        kind;
  logic [7:0]        out_byte;
  logic [7:0]        name_index;
  logic [SIZE_W-1:0] entry_size;
  logic [1:0]        name_source;
  logic [7:0]        entry_type;
  logic              last_of_run;

  arc_item_t   archive_bytes_q[$];
  result_t     parse_events_q[$];
  int unsigned err_count = 0;
  int unsigned send_wait = 0;
  int unsigned recv_wait = 0;
  bit          send_calm = 1'b0;
  bit          recv_calm = 1'b0;
  logic [7:0]  blk [BLOCK_BYTES];

  // Parser state mirror
  walk_t             walk;
  logic [8:0]        hdr_pos;
  logic              hdr_all_zero;
  logic              seen_zero_hdr;
  logic              suffix_closed;
  logic              prefix_closed;
  logic              has_prefix;
  size_scan_t        size_scan;
  logic [ACC_W-1:0]  size_acc;
  logic              size_neg;
  logic              magic_ok;
  logic [7:0]        hdr_type;
  logic              long_pending;
  logic [SIZE_W-1:0] content_left;
  logic [8:0]        pad_left;

  tar_ustar_stream_parser dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_stall   (byte_stall),
    .data_byte    (data_byte),
    .stream_end   (stream_end),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .kind         (kind),
    .out_byte     (out_byte),
    .name_index   (name_index),
    .entry_size   (entry_size),
    .name_source  (name_source),
    .entry_type   (entry_type),
    .last_of_run  (last_of_run)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------- predictor

  task automatic note_result(input logic [2:0] k, input logic [7:0] b,
                             input logic [7:0] idx, input logic [SIZE_W-1:0] sz,
                             input logic [1:0] src, input logic [7:0] typ,
                             input logic last);
    result_t r;
    r.kind        = k;
    r.out_byte    = b;
    r.name_index  = idx;
    r.entry_size  = sz;
    r.name_source = src;
    r.entry_type  = typ;
    r.last_of_run = last;
    parse_events_q.push_back(r);
  endtask

  task automatic restart_header();
    hdr_pos       = '0;
    hdr_all_zero  = 1'b1;
    suffix_closed = 1'b0;
    prefix_closed = 1'b0;
    has_prefix    = 1'b0;
    size_scan     = SZ_BLANK;
    size_acc      = '0;
    size_neg      = 1'b0;
    magic_ok      = 1'b1;
    hdr_type      = '0;
  endtask

  task automatic reset_parser();
    walk          = ST_HEADER;
    seen_zero_hdr = 1'b0;
    long_pending  = 1'b0;
    content_left  = '0;
    pad_left      = '0;
    restart_header();
  endtask

  // strtol-style scan: blanks, optional sign, octal digits
  task automatic scan_size_char(input logic [7:0] b);
    logic blank, digit;
    blank = (b == CH_SPACE) || (b >= 8'd9 && b <= 8'd13);
    digit = (b >= CH_ZERO) && (b <= CH_SEVEN);
    if (size_scan == SZ_BLANK && blank)
      return;
    if (size_scan == SZ_BLANK && (b == CH_PLUS || b == CH_MINUS)) begin
      size_neg  = (b == CH_MINUS);
      size_scan = SZ_SIGNED;
      return;
    end
    if (size_scan == SZ_BLANK || size_scan == SZ_SIGNED) begin
      if (digit) begin
        size_acc  = ACC_W'(b[2:0]);
        size_scan = SZ_DIGITS;
      end else begin
        // no digit at all: forced out of range
        size_acc  = '1;
        size_neg  = 1'b0;
        size_scan = SZ_STOPPED;
      end
      return;
    end
    if (size_scan == SZ_DIGITS) begin
      if (digit)
        size_acc = {size_acc[ACC_W-4:0], b[2:0]};
      else
        size_scan = SZ_STOPPED;
    end
  endtask

  task automatic leave_content();
    walk = (pad_left != 0) ? ST_PAD : ST_HEADER;
    if (walk == ST_HEADER)
      restart_header();
  endtask

  // Verdict or entry start at the last header byte
  task automatic close_header();
    logic [SIZE_W-1:0] sz;
    logic [1:0]        src;
    logic              bad;
    if (seen_zero_hdr) begin
      walk = ST_DONE;
      note_result(hdr_all_zero ? KIND_OK : KIND_ERROR, '0, '0, '0, '0, '0, 1'b0);
      return;
    end
    if (hdr_all_zero) begin
      seen_zero_hdr = 1'b1;
      restart_header();
      return;
    end
    bad = (size_scan == SZ_BLANK) || (size_scan == SZ_SIGNED) ||
          (size_neg && size_acc != 0) || (size_acc > MAX_ENTRY_SIZE);
    if (bad) begin
      walk = ST_DONE;
      note_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0);
      return;
    end
    if (!magic_ok) begin
      walk = ST_DONE;
      note_result(KIND_NOT_USTAR, '0, '0, '0, '0, '0, 1'b0);
      return;
    end
    sz           = size_acc[SIZE_W-1:0];
    src          = long_pending ? SRC_LONG : (has_prefix ? SRC_PREFIX : SRC_SUFFIX);
    long_pending = 1'b0;
    content_left = sz;
    pad_left     = 9'd0 - sz[8:0];
    note_result(KIND_ENTRY, '0, '0, sz, src, hdr_type, 1'b0);
    if (sz != 0) begin
      if (hdr_type == TYPE_REG_CHAR || hdr_type == TYPE_REG_NUL)
        walk = ST_FILE;
      else if (hdr_type == TYPE_LONG_NAME)
        walk = ST_LONG;
      else
        walk = ST_SKIP;
    end else begin
      if (hdr_type == TYPE_LONG_NAME)
        long_pending = 1'b1;
      leave_content();
    end
  endtask

  task automatic take_header_byte(input logic [7:0] b);
    int unsigned pos;
    pos = hdr_pos;
    if (b != 0)
      hdr_all_zero = 1'b0;
    if (pos < SUFFIX_END && !suffix_closed) begin
      if (b == 0)
        suffix_closed = 1'b1;
      else if (!seen_zero_hdr)
        note_result(KIND_SUFFIX, b, 8'(pos), '0, '0, '0, 1'b0);
    end
    if (pos >= PREFIX_FIRST && pos < PREFIX_END && !prefix_closed) begin
      if (pos == PREFIX_FIRST && b != 0)
        has_prefix = 1'b1;
      if (b == 0)
        prefix_closed = 1'b1;
      else if (!seen_zero_hdr)
        note_result(KIND_PREFIX, b, 8'(pos - PREFIX_FIRST), '0, '0, '0, 1'b0);
    end
    if (pos >= SIZE_FIRST && pos < SIZE_BOUND)
      scan_size_char(b);
    if (pos == TYPE_POS)
      hdr_type = b;
    if (pos >= MAGIC_FIRST && pos < MAGIC_FIRST + MAGIC_LEN &&
        b != USTAR_TEXT[39 - 8*(pos - MAGIC_FIRST) -: 8])
      magic_ok = 1'b0;
    if (pos == LAST_POS)
      close_header();
    else
      hdr_pos = 9'(pos + 1);
  endtask

  task automatic parse_archive_byte(input logic [7:0] b, input logic eos);
    walk_t was;
    logic  last;
    if (walk == ST_DONE)
      return;
    if (eos) begin
      // stream ended before a verdict
      walk = ST_DONE;
      note_result(KIND_ERROR, '0, '0, '0, '0, '0, 1'b0);
      return;
    end
    case (walk)
      ST_HEADER: begin
        take_header_byte(b);
      end
      ST_FILE, ST_LONG, ST_SKIP: begin
        was          = walk;
        content_left = content_left - 1'b1;
        last         = (content_left == 0);
        if (last) begin
          if (was == ST_LONG)
            long_pending = 1'b1;
          leave_content();
        end
        if (was == ST_FILE)
          note_result(KIND_CONTENT, b, '0, '0, '0, '0, last);
        else if (was == ST_LONG)
          note_result(KIND_LONG_NAME, b, '0, '0, '0, '0, last);
      end
      ST_PAD: begin
        pad_left = pad_left - 1'b1;
        if (pad_left == 0) begin
          walk = ST_HEADER;
          restart_header();
        end
      end
      default: begin
        walk = ST_DONE;
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  function automatic int unsigned pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 70)
      return 0;
    if (r < 96)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] nonzero_byte();
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [7:0] blank_byte();
    int unsigned r;
    r = $urandom_range(8, 13);
    return (r == 8) ? CH_SPACE : 8'(r);
  endfunction

  function automatic logic [7:0] non_octal_byte();
    logic [7:0] b;
    b = 8'($urandom);
    while (b >= CH_ZERO && b <= CH_SEVEN)
      b = 8'($urandom);
    return b;
  endfunction

  function automatic logic [7:0] octal_digit(input longint unsigned v, input int k);
    return CH_ZERO + 8'((v >> (3*k)) & 7);
  endfunction

  function automatic int unsigned pick_len(input int unsigned max_len);
    int unsigned r;
    r = $urandom_range(0, 5);
    if (r == 0)
      return 0;
    if (r == 1)
      return max_len;
    return $urandom_range(1, max_len - 1);
  endfunction

  function automatic int unsigned pick_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10)
      return 0;
    if (r < 60)
      return $urandom_range(1, 24);
    if (r < 85)
      return $urandom_range(25, 120);
    return $urandom_range(121, 700);
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic eos, input bit hold);
    arc_item_t it;
    it.b    = b;
    it.eos  = eos;
    it.hold = hold;
    archive_bytes_q.push_back(it);
  endtask

  task automatic send_block(input bit hold);
    for (int i = 0; i < BLOCK_BYTES; i++)
      send_byte(blk[i], 1'b0, hold && i == 0);
  endtask

  task automatic send_fill(input int unsigned n);
    for (int unsigned i = 0; i < n; i++)
      send_byte(8'($urandom), 1'b0, 1'b0);
  endtask

  task automatic zero_block();
    for (int i = 0; i < BLOCK_BYTES; i++)
      blk[i] = 8'h00;
  endtask

  // Header with names, type and magic; size field left to write_size
  task automatic make_header(input int unsigned name_len, input int unsigned pre_len,
                             input logic [7:0] typ, input bit junk);
    for (int i = 0; i < BLOCK_BYTES; i++)
      blk[i] = junk ? 8'($urandom) : 8'h00;
    for (int unsigned i = 0; i < SUFFIX_END; i++) begin
      if (i < name_len)
        blk[i] = nonzero_byte();
      else if (i == name_len)
        blk[i] = 8'h00;
    end
    for (int unsigned i = 0; i < PREFIX_SPAN; i++) begin
      if (i < pre_len)
        blk[PREFIX_FIRST + i] = nonzero_byte();
      else if (i == pre_len)
        blk[PREFIX_FIRST + i] = 8'h00;
    end
    blk[TYPE_POS] = typ;
    for (int k = 0; k < MAGIC_LEN; k++)
      blk[MAGIC_FIRST + k] = USTAR_TEXT[39 - 8*k -: 8];
  endtask

  // Well-formed size text: padded digits, loose text, or a full field of digits
  task automatic write_size(input longint unsigned size, input int style);
    int pos, ndig, nws, sgn;
    for (int i = 0; i < SIZE_LEN; i++)
      blk[SIZE_FIRST + i] = 8'h00;
    case (style)
      0: begin
        for (int k = 0; k < 11; k++)
          blk[SIZE_FIRST + k] = octal_digit(size, 10 - k);
        blk[SIZE_FIRST + 11] = $urandom_range(0, 1) ? CH_SPACE : 8'h00;
      end
      1: begin
        ndig = 1;
        while (ndig < 11 && (size >> (3*ndig)) != 0)
          ndig++;
        nws = $urandom_range(0, 3);
        sgn = $urandom_range(0, 2);
        if (sgn == 2 && size != 0)
          sgn = 1;
        while (nws + (sgn != 0) + ndig > SIZE_LEN) begin
          if (nws > 0)
            nws--;
          else
            sgn = 0;
        end
        pos = 0;
        for (int i = 0; i < nws; i++) begin
          blk[SIZE_FIRST + pos] = blank_byte();
          pos++;
        end
        if (sgn != 0) begin
          blk[SIZE_FIRST + pos] = (sgn == 2) ? CH_MINUS : CH_PLUS;
          pos++;
        end
        for (int k = ndig - 1; k >= 0; k--) begin
          blk[SIZE_FIRST + pos] = octal_digit(size, k);
          pos++;
        end
        if (pos < SIZE_LEN) begin
          blk[SIZE_FIRST + pos] = non_octal_byte();
          pos++;
        end
        while (pos < SIZE_LEN) begin
          blk[SIZE_FIRST + pos] = 8'($urandom);
          pos++;
        end
      end
      default: begin
        for (int k = 0; k < 12; k++)
          blk[SIZE_FIRST + k] = octal_digit(size, 11 - k);
      end
    endcase
  endtask

  // Size text that must be rejected
  task automatic write_bad_size();
    int n;
    for (int i = 0; i < SIZE_LEN; i++)
      blk[SIZE_FIRST + i] = 8'h00;
    case ($urandom_range(0, 4))
      0: begin
        // blanks only
        for (int i = 0; i < SIZE_LEN; i++)
          blk[SIZE_FIRST + i] = blank_byte();
      end
      1: begin
        // blanks, then a stray character
        n = $urandom_range(0, 11);
        for (int i = 0; i < n; i++)
          blk[SIZE_FIRST + i] = blank_byte();
        case ($urandom_range(0, 3))
          0:       blk[SIZE_FIRST + n] = 8'h00;
          1:       blk[SIZE_FIRST + n] = "x";
          2:       blk[SIZE_FIRST + n] = "8";
          default: blk[SIZE_FIRST + n] = "9";
        endcase
      end
      2: begin
        // sign with no digit after it
        n = $urandom_range(0, 11);
        for (int i = 0; i < n; i++)
          blk[SIZE_FIRST + i] = blank_byte();
        blk[SIZE_FIRST + n] = $urandom_range(0, 1) ? CH_MINUS : CH_PLUS;
        if (n < 11)
          blk[SIZE_FIRST + n + 1] = $urandom_range(0, 1) ? CH_SPACE : 8'h00;
      end
      3: begin
        // negative nonzero value
        blk[SIZE_FIRST] = CH_MINUS;
        blk[SIZE_FIRST + 1] = CH_ZERO + 8'($urandom_range(1, 7));
        for (int i = 2; i < 6; i++)
          blk[SIZE_FIRST + i] = CH_ZERO + 8'($urandom_range(0, 7));
      end
      default: begin
        // above the size limit
        if ($urandom_range(0, 1)) begin
          write_size(longint'(MAX_ENTRY_SIZE) + 1, 0);
        end else begin
          blk[SIZE_FIRST] = CH_ZERO + 8'($urandom_range(1, 7));
          for (int i = 1; i < SIZE_LEN; i++)
            blk[SIZE_FIRST + i] = CH_ZERO + 8'($urandom_range(0, 7));
        end
      end
    endcase
  endtask

  task automatic send_body(input int unsigned size, input bit nul_rich);
    for (int unsigned i = 0; i < size; i++)
      send_byte((nul_rich && $urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
                1'b0, 1'b0);
    send_fill((BLOCK_BYTES - size % BLOCK_BYTES) % BLOCK_BYTES);
  endtask

  task automatic random_entry(input bit hold);
    int unsigned r, size;
    logic [7:0]  typ;
    r = $urandom_range(0, 9);
    if (r < 4)
      typ = TYPE_REG_CHAR;
    else if (r < 6)
      typ = TYPE_REG_NUL;
    else if (r < 8)
      typ = TYPE_LONG_NAME;
    else if (r == 8)
      typ = "5";
    else
      typ = 8'($urandom);
    size = pick_size();
    make_header(pick_len(SUFFIX_END), $urandom_range(0, 1) ? 0 : pick_len(PREFIX_SPAN),
                typ, 1'($urandom_range(0, 1)));
    write_size(size, $urandom_range(0, 2));
    send_block(hold);
    send_body(size, typ == TYPE_LONG_NAME);
  endtask

  // Archive ending, then bytes the parser must ignore
  task automatic finish_archive();
    int unsigned size, m;
    logic [7:0]  b;
    int          k;
    case ($urandom_range(0, 5))
      0: begin
        // end-of-archive marker
        zero_block();
        send_block(1'b1);
        send_block(1'b0);
      end
      1: begin
        // nonzero header after a zero header
        zero_block();
        send_block(1'b1);
        if ($urandom_range(0, 1)) begin
          make_header(pick_len(SUFFIX_END), pick_len(PREFIX_SPAN), TYPE_REG_CHAR, 1'b1);
          write_size(pick_size(), $urandom_range(0, 2));
        end else begin
          zero_block();
          blk[$urandom_range(0, LAST_POS)] = nonzero_byte();
        end
        send_block(1'b0);
      end
      2: begin
        make_header(pick_len(SUFFIX_END), pick_len(PREFIX_SPAN), TYPE_REG_CHAR,
                    1'($urandom_range(0, 1)));
        write_bad_size();
        send_block(1'b1);
      end
      3: begin
        // broken magic
        make_header(pick_len(SUFFIX_END), pick_len(PREFIX_SPAN), TYPE_REG_CHAR,
                    1'($urandom_range(0, 1)));
        write_size(pick_size(), $urandom_range(0, 2));
        k = $urandom_range(0, MAGIC_LEN - 1);
        b = 8'($urandom);
        while (b == USTAR_TEXT[39 - 8*k -: 8])
          b = 8'($urandom);
        blk[MAGIC_FIRST + k] = b;
        send_block(1'b1);
      end
      4: begin
        // truncation inside a header, content or padding
        size = $urandom_range(1, 100);
        make_header(pick_len(SUFFIX_END), 0, TYPE_REG_CHAR, 1'b0);
        write_size(size, 0);
        m = $urandom_range(0, LAST_POS);
        if ($urandom_range(0, 1)) begin
          for (int unsigned i = 0; i < m; i++)
            send_byte(blk[i], 1'b0, i == 0);
          send_byte(8'($urandom), 1'b1, m == 0);
        end else begin
          send_block(1'b1);
          send_fill(m);
          send_byte(8'($urandom), 1'b1, 1'b0);
        end
      end
      default: begin
        // largest legal size, cut short
        r_type_huge: begin
          case ($urandom_range(0, 2))
            0:       b = TYPE_REG_CHAR;
            1:       b = TYPE_LONG_NAME;
            default: b = "x";
          endcase
        end
        make_header(pick_len(SUFFIX_END), pick_len(PREFIX_SPAN), b, 1'b0);
        write_size(longint'(MAX_ENTRY_SIZE), $urandom_range(0, 1) ? 0 : 2);
        send_block(1'b1);
        send_fill($urandom_range(1, 50));
        send_byte(8'($urandom), 1'b1, 1'b0);
      end
    endcase
    send_fill($urandom_range(2, 6));
    send_byte(8'($urandom), 1'b1, 1'b0);
    repeat ($urandom_range(2, 6))
      send_byte(8'($urandom), 1'($urandom_range(0, 1)), 1'b0);
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
      data_byte  <= 8'h00;
      stream_end <= 1'b0;
      send_wait  <= 0;
      send_calm  <= 1'b0;
      reset_parser();
    end else begin
      if (byte_valid && !byte_stall)
        parse_archive_byte(data_byte, stream_end);
      if ($urandom_range(0, 299) == 0)
        send_calm <= !send_calm;
      if (!byte_valid || !byte_stall) begin
        if (send_wait != 0) begin
          byte_valid <= 1'b0;
          send_wait  <= send_wait - 1;
        end else if (archive_bytes_q.size() != 0 &&
                     !(archive_bytes_q[0].hold && parse_events_q.size() != 0)) begin
          byte_valid <= 1'b1;
          data_byte  <= archive_bytes_q[0].b;
          stream_end <= archive_bytes_q[0].eos;
          void'(archive_bytes_q.pop_front());
          send_wait  <= pick_gap(send_calm);
        end else begin
          byte_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic check_result();
    result_t want;
    logic    bad;
    if (parse_events_q.size() == 0) begin
      err_count++;
      if (err_count <= 10)
        $display("unexpected transfer: kind %0d byte %02h idx %0d size %0d",
                 kind, out_byte, name_index, entry_size);
      return;
    end
    want = parse_events_q.pop_front();
    bad = (kind !== want.kind) || (out_byte !== want.out_byte) ||
          (name_index !== want.name_index) || (entry_size !== want.entry_size) ||
          (name_source !== want.name_source) || (entry_type !== want.entry_type) ||
          (last_of_run !== want.last_of_run);
    if (bad) begin
      err_count++;
      if (err_count <= 10) begin
        $display("mismatch: exp kind %0d byte %02h idx %0d size %0d src %0d type %02h last %0d",
                 want.kind, want.out_byte, want.name_index, want.entry_size,
                 want.name_source, want.entry_type, want.last_of_run);
        $display("          got kind %0d byte %02h idx %0d size %0d src %0d type %02h last %0d",
                 kind, out_byte, name_index, entry_size, name_source, entry_type,
                 last_of_run);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      recv_wait    <= 0;
      recv_calm    <= 1'b0;
    end else begin
      if (result_valid && !result_stall)
        check_result();
      if ($urandom_range(0, 299) == 0)
        recv_calm <= !recv_calm;
      if (recv_wait != 0) begin
        result_stall <= 1'b1;
        recv_wait    <= recv_wait - 1;
      end else begin
        result_stall <= 1'b0;
        recv_wait    <= pick_gap(recv_calm);
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    // long-name entry: full suffix and prefix, blanks and '+' in the size,
    // content with embedded NULs
    make_header(SUFFIX_END, PREFIX_SPAN, TYPE_LONG_NAME, 1'b1);
    blk[0] = 8'hFF;
    blk[1] = 8'h01;
    blk[PREFIX_FIRST] = 8'hFF;
    blk[PREFIX_END - 1] = 8'h01;
    blk[SIZE_FIRST] = CH_SPACE;
    blk[SIZE_FIRST + 1] = 8'h09;
    blk[SIZE_FIRST + 2] = CH_PLUS;
    blk[SIZE_FIRST + 3] = "5";
    blk[SIZE_FIRST + 4] = "8";
    send_block(1'b0);
    send_byte("a", 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte("b", 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    send_byte(8'h00, 1'b0, 1'b0);
    send_fill(BLOCK_BYTES - 5);

    // empty long name: size "-0", no names
    make_header(0, 0, TYPE_LONG_NAME, 1'b0);
    blk[SIZE_FIRST] = CH_MINUS;
    blk[SIZE_FIRST + 1] = CH_ZERO;
    send_block(1'b0);

    // random entries up to the byte budget
    while (archive_bytes_q.size() < ARCHIVE_BYTES)
      random_entry($urandom_range(0, 5) == 0);
    finish_archive();

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    while (archive_bytes_q.size() != 0 || byte_valid)
      @(posedge clk);
    while (parse_events_q.size() != 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0 && parse_events_q.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
